### rtl/sorted_priority_queue_by_key_defines.svh
// Assertion macros shared by the queue RTL
`ifndef SORTED_PRIORITY_QUEUE_BY_KEY_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_BY_KEY_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPQK_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPQK_ASSERT_IMP(label, ante, cons)
`define SPQK_ASSERT_NXT(label, ante, cons)
`endif

`endif

### rtl/spqk_pkg.sv
// Types and codes shared by the queue cells and the queue top level
package spqk_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_POP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_POP    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_INSERT = 2'd3
    } cell_op_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_INSERT = 1'b1
    } state_t;

    typedef struct packed {
        logic ge;
        logic found;
    } link_t;

endpackage

### rtl/spqk_cell.sv
// One queue slot: holds an entry, compares it and shifts with its neighbors
module spqk_cell #(
    parameter int KEY_WIDTH      = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                      clk,
    input  spqk_pkg::cell_op_t        op,
    input  logic                      valid,
    input  logic [KEY_WIDTH-1:0]      cmd_key,
    input  logic [PRIORITY_WIDTH-1:0] cmd_prio,
    input  logic [KEY_WIDTH-1:0]      left_key,
    input  logic [PRIORITY_WIDTH-1:0] left_prio,
    input  spqk_pkg::link_t           left_link,
    input  logic [KEY_WIDTH-1:0]      right_key,
    input  logic [PRIORITY_WIDTH-1:0] right_prio,
    output logic [KEY_WIDTH-1:0]      key_q,
    output logic [PRIORITY_WIDTH-1:0] prio_q,
    output logic [KEY_WIDTH-1:0]      key_nx,
    output logic [PRIORITY_WIDTH-1:0] prio_nx,
    output spqk_pkg::link_t           link_out
);
    import spqk_pkg::*;

    logic [KEY_WIDTH-1:0]      key_reg;
    logic [KEY_WIDTH-1:0]      key_next;
    logic [PRIORITY_WIDTH-1:0] prio_reg;
    logic [PRIORITY_WIDTH-1:0] prio_next;
    logic                      match;
    logic                      ge;

    assign match = valid && (key_reg == cmd_key);
    assign ge    = valid && (prio_reg >= cmd_prio);

    assign link_out.ge    = ge;
    assign link_out.found = left_link.found || match;

    always_comb
    begin
        key_next  = key_reg;
        prio_next = prio_reg;
        case (op)
            OP_POP:
            begin
                key_next  = right_key;
                prio_next = right_prio;
            end
            OP_CANCEL:
            begin
                if (left_link.found || match)
                begin
                    key_next  = right_key;
                    prio_next = right_prio;
                end
            end
            OP_INSERT:
            begin
                if (!ge)
                begin
                    if (left_link.ge)
                    begin
                        key_next  = cmd_key;
                        prio_next = cmd_prio;
                    end
                    else
                    begin
                        key_next  = left_key;
                        prio_next = left_prio;
                    end
                end
            end
            default:
            begin
                key_next  = key_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

    assign key_q   = key_reg;
    assign prio_q  = prio_reg;
    assign key_nx  = key_next;
    assign prio_nx = prio_next;

endmodule

### rtl/sorted_priority_queue_by_key.sv
// Priority queue top level: command control, count and result register
// Flow: a command is taken in ST_IDLE and its result is registered in ST_INSERT once
// the output side is free, so a result can wait in ST_INSERT while the output stalls.
// Commands: no new command is taken until the last result is registered; the remove pass
// runs as a command is taken, the insert pass in ST_INSERT, each across the row of cells.
// Reset: rst_n clears the entry count, the control state and the output valid.
module sorted_priority_queue_by_key #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int KEY_WIDTH      = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // key, priority_req
    input  logic [((KEY_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0] s_tdata,
    // mode
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // status, entry_count, front_valid, front_key, front_priority
    output logic [((3+$clog2(QUEUE_DEPTH+1)+KEY_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0] m_tdata
);
    import spqk_pkg::*;

    `include "sorted_priority_queue_by_key_defines.svh"

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W   = 3 + CNT_W + KEY_WIDTH + PRIORITY_WIDTH;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [KEY_WIDTH-1:0]      cmd_key_reg;
    logic [PRIORITY_WIDTH-1:0] cmd_prio_reg;
    status_t                   status_reg;
    status_t                   status_next;
    logic                      insert_reg;
    logic                      insert_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [OUT_PAD-1:0]        m_data_reg;
    logic [OUT_PAD-1:0]        m_data_next;

    mode_t                     s_mode;
    logic [KEY_WIDTH-1:0]      s_key;
    logic [PRIORITY_WIDTH-1:0] s_prio;
    logic                      accept;
    logic                      emit;
    logic                      full;
    logic                      found;
    cell_op_t                  op;
    logic [KEY_WIDTH-1:0]      cell_key;
    logic [PRIORITY_WIDTH-1:0] cell_prio;
    logic [CNT_W-1:0]          emit_count;
    logic                      emit_front;

    logic [KEY_WIDTH-1:0]      key_q   [QUEUE_DEPTH];
    logic [PRIORITY_WIDTH-1:0] prio_q  [QUEUE_DEPTH];
    logic [KEY_WIDTH-1:0]      key_nx  [QUEUE_DEPTH];
    logic [PRIORITY_WIDTH-1:0] prio_nx [QUEUE_DEPTH];
    link_t                     link    [QUEUE_DEPTH];

    assign s_mode = mode_t'(s_tuser);
    assign s_key  = s_tdata[KEY_WIDTH-1:0];
    assign s_prio = s_tdata[KEY_WIDTH+PRIORITY_WIDTH-1:KEY_WIDTH];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign emit     = (state_reg == ST_INSERT) && (!m_valid_reg || m_tready);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign found    = link[QUEUE_DEPTH-1].found;

    assign cell_key  = (state_reg == ST_IDLE) ? s_key : cmd_key_reg;
    assign cell_prio = (state_reg == ST_IDLE) ? s_prio : cmd_prio_reg;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic [KEY_WIDTH-1:0]      lk;
            logic [PRIORITY_WIDTH-1:0] lp;
            link_t                     ll;
            logic [KEY_WIDTH-1:0]      rk;
            logic [PRIORITY_WIDTH-1:0] rp;

            if (gi == 0)
            begin : g_first
                assign lk       = cell_key;
                assign lp       = cell_prio;
                assign ll.ge    = 1'b1;
                assign ll.found = 1'b0;
            end
            else
            begin : g_mid
                assign lk = key_q[gi-1];
                assign lp = prio_q[gi-1];
                assign ll = link[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign rk = key_q[gi];
                assign rp = prio_q[gi];
            end
            else
            begin : g_inner
                assign rk = key_q[gi+1];
                assign rp = prio_q[gi+1];
            end

            spqk_cell #(
                .KEY_WIDTH      (KEY_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .valid      (CNT_W'(gi) < count_reg),
                .cmd_key    (cell_key),
                .cmd_prio   (cell_prio),
                .left_key   (lk),
                .left_prio  (lp),
                .left_link  (ll),
                .right_key  (rk),
                .right_prio (rp),
                .key_q      (key_q[gi]),
                .prio_q     (prio_q[gi]),
                .key_nx     (key_nx[gi]),
                .prio_nx    (prio_nx[gi]),
                .link_out   (link[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        op           = OP_HOLD;
        count_next   = count_reg;
        status_next  = status_reg;
        insert_next  = insert_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        emit_count   = count_reg + CNT_W'(insert_reg);
        emit_front   = (emit_count != '0);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_DONE;
                    insert_next = 1'b0;
                    unique case (s_mode) inside
                        MODE_ADD:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                insert_next = 1'b1;
                            end
                        end
                        MODE_CANCEL, MODE_UPDATE:
                        begin
                            op = OP_CANCEL;
                            if (found)
                            begin
                                count_next  = count_reg - CNT_W'(1);
                                insert_next = (s_mode == MODE_UPDATE);
                            end
                            else
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                op         = OP_POP;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    endcase
                end
            end
            ST_INSERT:
            begin
                if (emit)
                begin
                    if (insert_reg)
                    begin
                        op = OP_INSERT;
                    end
                    count_next   = emit_count;
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_PAD'({
                        emit_front ? prio_nx[0] : PRIORITY_WIDTH'(0),
                        emit_front ? key_nx[0] : KEY_WIDTH'(0),
                        emit_front,
                        emit_count,
                        status_reg
                    });
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_key_reg  <= s_key;
            cmd_prio_reg <= s_prio;
        end
        status_reg <= status_next;
        insert_reg <= insert_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SPQK_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `SPQK_ASSERT_NXT(a_count_step, 1'b1,
        (count_reg == $past(count_reg)) ||
        (count_reg == $past(count_reg) + CNT_W'(1)) ||
        (count_reg == $past(count_reg) - CNT_W'(1)))
    `SPQK_ASSERT_NXT(a_full_drop, accept && (s_mode == MODE_ADD) && full,
        (status_reg == STAT_FULL) && !insert_reg && (count_reg == $past(count_reg)))
    `SPQK_ASSERT_IMP(a_front_flag, m_valid_reg,
        m_data_reg[2+CNT_W] == (m_data_reg[CNT_W+1:2] != '0))

endmodule
